// ----- rtl/kef_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kef_pkg;

	// Defaults for the top-level parameters.
	localparam int FIFO_DEPTH_DEF = 128;
	localparam int KEY_COUNT_DEF  = 64;

	// Fixed field widths.
	localparam int KEY_W     = 8;
	localparam int KIND_W    = 3;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Register reset values.
	localparam logic [CNT_W-1:0] REPEAT_PERIOD_RST = 16'd75;
	localparam logic [CNT_W-1:0] FIRST_DELAY_RST   = 16'd225;

	// Event codes.
	typedef enum logic [KIND_W-1:0] {
		KIND_DOWN  = 3'd0,
		KIND_UP    = 3'd1,
		KIND_TICK  = 3'd2,
		KIND_POLL  = 3'd3,
		KIND_POP   = 3'd4,
		KIND_CLEAR = 3'd5
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPEAT_PERIOD = 2'd0,
		REG_FIRST_DELAY   = 2'd1
	} cfg_reg_t;

	// Input item.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key_code;
	} kef_in_t;

	// Result item.
	typedef struct packed {
		logic [KEY_W-1:0] popped_key;
		logic             popped_valid;
		logic             push_accepted;
		logic             fifo_not_empty;
		logic             key_is_held;
	} kef_out_t;

	// Commands from the repeat logic to the key FIFO.
	typedef struct packed {
		logic             push;
		logic [KEY_W-1:0] push_key;
		logic             pop;
		logic             clear;
	} kef_fifo_cmd_t;

	// Per-step outcome reported by the key FIFO.
	typedef struct packed {
		logic push_ok;
		logic pop_valid;
		logic bypass;
		logic not_empty;
	} kef_fifo_res_t;

endpackage

`default_nettype wire

// ----- rtl/kef_repeat.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kef_repeat #(
	parameter int KEY_COUNT = kef_pkg::KEY_COUNT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [kef_pkg::KIND_W-1:0] kind,
	input  wire logic [kef_pkg::KEY_W-1:0]  key_code,
	input  wire logic [kef_pkg::CNT_W-1:0]  repeat_period,
	input  wire logic [kef_pkg::CNT_W-1:0]  first_repeat_delay,
	output kef_pkg::kef_fifo_cmd_t          cmd,
	output logic                            key_is_held
);

	import kef_pkg::*;

	localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

	logic [KEY_COUNT-1:0] held_q, held_d;
	logic                 tracking_q, tracking_d;
	logic [KEY_W-1:0]     tracked_key_q, tracked_key_d;
	logic [CNT_W-1:0]     countdown_q, countdown_d;
	logic                 key_in_range;
	logic                 tracked_in_range;
	logic                 repeat_due;

	assign key_in_range     = {1'b0, key_code} < (KEY_W + 1)'(KEY_COUNT);
	assign tracked_in_range = {1'b0, tracked_key_q} < (KEY_W + 1)'(KEY_COUNT);
	assign repeat_due       = tracking_q && (countdown_q == '0);

	// Next-state decode for one event.
	always_comb begin
		held_d        = held_q;
		tracking_d    = tracking_q;
		tracked_key_d = tracked_key_q;
		countdown_d   = countdown_q;
		cmd           = '0;
		case (kind)
			KIND_DOWN: begin
				if (!tracking_q) begin
					tracking_d    = 1'b1;
					tracked_key_d = key_code;
					countdown_d   = first_repeat_delay;
				end
				if (key_in_range) begin
					held_d[key_code[IDX_W-1:0]] = 1'b1;
				end
				cmd.push     = 1'b1;
				cmd.push_key = key_code;
			end
			KIND_UP: begin
				tracking_d = 1'b0;
				if (key_in_range) begin
					held_d[key_code[IDX_W-1:0]] = 1'b0;
				end
			end
			KIND_TICK: begin
				if (countdown_q != '0) begin
					countdown_d = countdown_q - 1'b1;
				end
			end
			KIND_POLL, KIND_POP: begin
				// An expired countdown pushes the tracked key again.
				if (repeat_due) begin
					if (tracked_in_range) begin
						held_d[tracked_key_q[IDX_W-1:0]] = 1'b1;
					end
					cmd.push     = 1'b1;
					cmd.push_key = tracked_key_q;
					countdown_d  = repeat_period;
				end
				cmd.pop = (kind == KIND_POP);
			end
			KIND_CLEAR: begin
				held_d     = '0;
				tracking_d = 1'b0;
				cmd.clear  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// The held bit is reported after this event's update.
	assign key_is_held = key_in_range && held_d[key_code[IDX_W-1:0]];

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q        <= '0;
			tracking_q    <= 1'b0;
			tracked_key_q <= '0;
			countdown_q   <= '0;
		end else if (step) begin
			held_q        <= held_d;
			tracking_q    <= tracking_d;
			tracked_key_q <= tracked_key_d;
			countdown_q   <= countdown_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/kef_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kef_fifo #(
	parameter int FIFO_DEPTH = kef_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step,
	input  wire kef_pkg::kef_fifo_cmd_t    cmd,
	output kef_pkg::kef_fifo_res_t         res,
	output logic [kef_pkg::KEY_W-1:0]      rd_data
);

	import kef_pkg::*;

	localparam int               PTR_W    = $clog2(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(FIFO_DEPTH - 1);

	logic [KEY_W-1:0] mem [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [PTR_W-1:0] tail_inc, head_inc;
	logic [PTR_W-1:0] tail_after, head_after;

	// Ring pointer arithmetic; one slot stays free to tell full from empty.
	assign tail_inc    = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign head_inc    = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign res.push_ok = cmd.push && (tail_inc != head_q);
	assign tail_after  = res.push_ok ? tail_inc : tail_q;
	assign res.pop_valid = cmd.pop && (head_q != tail_after);
	assign head_after  = res.pop_valid ? head_inc : head_q;
	// A pop that follows a push into an empty FIFO takes the pushed key.
	assign res.bypass    = res.push_ok && (tail_q == head_q);
	assign res.not_empty = !cmd.clear && (head_after != tail_after);

	// Pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (step) begin
			if (cmd.clear) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				head_q <= head_after;
				tail_q <= tail_after;
			end
		end
	end

	// Key storage: one write and one registered read per step.
	always_ff @(posedge clk) begin
		if (step) begin
			if (res.push_ok) begin
				mem[tail_q] <= cmd.push_key;
			end
			rd_data <= mem[head_q];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/key_event_fifo_with_autorepeat.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Keyboard buffer with typematic repeat.
// Events (key down, key up, tick, poll, pop, clear) arrive on the input
// channel as one transfer each, qualified by in_valid and in_stall. Every
// event yields exactly one result transfer on the output channel carrying
// the popped key, the drop flag, the FIFO status and the held bit of the
// event's key code.
// An event is held in the input register, decoded there and moved into the
// output register once that register is empty or being taken. One event per
// cycle is sustained while out_stall stays low; the key store is a
// single-write, single-read memory with a registered read port.
// The two configuration registers are written over the cfg channel, which
// is always ready; writes belong to idle periods between events.
// Reset clears the pointers, the held-key bitmap, tracking and the
// countdown, and loads the registers with their defaults. The key store
// itself is not cleared. When out_stall holds the output register, the
// input register keeps its event and in_stall rises until the result moves.
module key_event_fifo_with_autorepeat #(
	parameter int FIFO_DEPTH = kef_pkg::FIFO_DEPTH_DEF,
	parameter int KEY_COUNT  = kef_pkg::KEY_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire kef_pkg::kef_in_t              in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output kef_pkg::kef_out_t                  out_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [kef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kef_pkg::CNT_W-1:0]     cfg_data
);

	import kef_pkg::*;

	logic             s1_valid_q;
	kef_in_t          s1_data;
	logic             advance;
	logic             step;
	logic [CNT_W-1:0] repeat_period_q;
	logic [CNT_W-1:0] first_delay_q;
	kef_fifo_cmd_t    fifo_cmd;
	kef_fifo_res_t    fifo_res;
	logic [KEY_W-1:0] rd_data;
	logic             held_now;
	logic             out_valid_q;
	logic             pvalid_s2;
	logic             bypass_s2;
	logic [KEY_W-1:0] bypass_key_s2;
	logic             accepted_s2;
	logic             not_empty_s2;
	logic             held_s2;

	// The output register frees up when it is empty or being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign step     = s1_valid_q && advance;
	assign in_stall = s1_valid_q && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			s1_data <= in_data;
		end
	end

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_period_q <= REPEAT_PERIOD_RST;
			first_delay_q   <= FIRST_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REPEAT_PERIOD: repeat_period_q <= cfg_data;
				REG_FIRST_DELAY:   first_delay_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	kef_repeat #(
		.KEY_COUNT(KEY_COUNT)
	) u_repeat (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.kind              (s1_data.kind),
		.key_code          (s1_data.key_code),
		.repeat_period     (repeat_period_q),
		.first_repeat_delay(first_delay_q),
		.cmd               (fifo_cmd),
		.key_is_held       (held_now)
	);

	kef_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (fifo_cmd),
		.res    (fifo_res),
		.rd_data(rd_data)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pvalid_s2     <= fifo_res.pop_valid;
			bypass_s2     <= fifo_res.bypass;
			bypass_key_s2 <= fifo_cmd.push_key;
			accepted_s2   <= !fifo_cmd.push || fifo_res.push_ok;
			not_empty_s2  <= fifo_res.not_empty;
			held_s2       <= held_now;
		end
	end

	assign out_valid               = out_valid_q;
	assign out_data.popped_key     = pvalid_s2 ? (bypass_s2 ? bypass_key_s2 : rd_data) : '0;
	assign out_data.popped_valid   = pvalid_s2;
	assign out_data.push_accepted  = accepted_s2;
	assign out_data.fifo_not_empty = not_empty_s2;
	assign out_data.key_is_held    = held_s2;

	// A dropped push means the FIFO was full, so it cannot be empty afterward.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.push_accepted |-> out_data.fifo_not_empty)
		else $error("push dropped while FIFO reported empty");

	// No key is shown when nothing was popped.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.popped_valid |-> out_data.popped_key == '0)
		else $error("popped key nonzero without a pop");

	// The input side only stalls while an event waits in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && out_valid_q)
		else $error("input stalled with no event pending");

	// An event in the input register reaches the output register when it moves.
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("processed event produced no result");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import kef_pkg::*;

	localparam int FIFO_DEPTH     = FIFO_DEPTH_DEF;
	localparam int KEY_COUNT      = KEY_COUNT_DEF;
	localparam int MAX_GAP        = 17;
	localparam int LONG_HOLD      = 90;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;

	// Event codes that the block must leave without effect.
	localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

	// Register indexes with no register behind them.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	kef_in_t              in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	kef_out_t             out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_data  = '0;

	key_event_fifo_with_autorepeat dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Free-running clock.
	always #5 clk = ~clk;

	// Predicted keyboard buffer state.
	logic [KEY_W-1:0] ring [FIFO_DEPTH];
	int unsigned      ring_head = 0;
	int unsigned      ring_tail = 0;
	bit               held_keys [KEY_COUNT];
	bit               repeat_armed = 1'b0;
	logic [KEY_W-1:0] armed_key = '0;
	logic [CNT_W-1:0] ticks_left = '0;
	logic [CNT_W-1:0] cur_period = REPEAT_PERIOD_RST;
	logic [CNT_W-1:0] cur_first_delay = FIRST_DELAY_RST;

	// Results predicted but not yet seen on the output channel.
	kef_out_t report_q [$];

	// Idling controls shared between the test tasks and the result sink.
	bit tx_idle_on  = 1'b1;
	bit rx_idle_on  = 1'b1;
	int rx_hold_len = 0;

	// Run statistics.
	int events_sent    = 0;
	int results_seen   = 0;
	int mismatches     = 0;
	int repeats_pushed = 0;
	int drops_seen     = 0;
	int pops_seen      = 0;
	int stalled_offers = 0;
	int long_holds     = 0;
	int cfg_writes     = 0;
	int quiet_cycles   = 0;

	// Push one code into the predicted ring; the ring keeps one slot free.
	function automatic bit ring_put(logic [KEY_W-1:0] code);
		int unsigned nxt;
		nxt = (ring_tail + 1) % FIFO_DEPTH;
		if (nxt == ring_head) begin
			drops_seen++;
			return 1'b0;
		end
		ring[ring_tail] = code;
		ring_tail = nxt;
		return 1'b1;
	endfunction

	// Typematic repeat: an expired countdown on a tracked key pushes it again.
	function automatic bit fire_repeat();
		if (!repeat_armed || ticks_left != 0)
			return 1'b1;
		if (armed_key < KEY_COUNT)
			held_keys[armed_key] = 1'b1;
		ticks_left = cur_period;
		repeats_pushed++;
		return ring_put(armed_key);
	endfunction

	// Advance the predicted state by one event and return the expected result.
	function automatic kef_out_t typematic_step(kef_in_t ev);
		kef_out_t r;
		r = '0;
		r.push_accepted = 1'b1;
		case (ev.kind)
			KIND_DOWN: begin
				if (!repeat_armed) begin
					repeat_armed = 1'b1;
					armed_key = ev.key_code;
					ticks_left = cur_first_delay;
				end
				if (ev.key_code < KEY_COUNT)
					held_keys[ev.key_code] = 1'b1;
				r.push_accepted = ring_put(ev.key_code);
			end
			KIND_UP: begin
				repeat_armed = 1'b0;
				if (ev.key_code < KEY_COUNT)
					held_keys[ev.key_code] = 1'b0;
			end
			KIND_TICK: begin
				if (ticks_left != 0)
					ticks_left--;
			end
			KIND_POLL: begin
				r.push_accepted = fire_repeat();
			end
			KIND_POP: begin
				r.push_accepted = fire_repeat();
				if (ring_head != ring_tail) begin
					r.popped_key = ring[ring_head];
					r.popped_valid = 1'b1;
					ring_head = (ring_head + 1) % FIFO_DEPTH;
					pops_seen++;
				end
			end
			KIND_CLEAR: begin
				ring_head = 0;
				ring_tail = 0;
				foreach (held_keys[i])
					held_keys[i] = 1'b0;
				repeat_armed = 1'b0;
			end
			default: ;
		endcase
		r.fifo_not_empty = ring_head != ring_tail;
		r.key_is_held = ev.key_code < KEY_COUNT && held_keys[ev.key_code];
		return r;
	endfunction

	function automatic string fmt_report(kef_out_t r);
		return $sformatf("key=%02h popped=%b accepted=%b not_empty=%b held=%b",
			r.popped_key, r.popped_valid, r.push_accepted, r.fifo_not_empty,
			r.key_is_held);
	endfunction

	// Offer one event and wait for its transfer. Valid stays high afterwards
	// so that a back-to-back event needs only one assignment per edge.
	task automatic send_event(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] code);
		int      gap;
		kef_in_t ev;
		gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
		ev.kind = kind;
		ev.key_code = code;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ev;
		do @(posedge clk); while (in_stall !== 1'b0);
		report_q.push_back(typematic_step(ev));
		events_sent++;
	endtask

	// Drop valid and wait until every outstanding result has been checked.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Register write over the configuration channel, only while idle.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			REG_REPEAT_PERIOD: cur_period = value;
			REG_FIRST_DELAY:   cur_first_delay = value;
			default: ;
		endcase
	endtask

	task automatic set_timing(logic [CNT_W-1:0] first_delay, logic [CNT_W-1:0] period);
		write_reg(REG_FIRST_DELAY, first_delay);
		write_reg(REG_REPEAT_PERIOD, period);
	endtask

	task automatic send_noise();
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  code;
		kind = KIND_W'($urandom_range(0, 7));
		code = KEY_W'($urandom_range(0, 255));
		send_event(kind, code);
	endtask

	// A well-formed keystroke: press, let time pass with polls and pops,
	// maybe roll over onto a second key, then release.
	task automatic type_key_sequence();
		logic [KEY_W-1:0] code;
		logic [KEY_W-1:0] other;
		int               steps;
		if ($urandom_range(0, 4) == 0)
			code = KEY_W'($urandom_range(0, 255));
		else
			code = KEY_W'($urandom_range(0, KEY_COUNT - 1));
		other = KEY_W'($urandom_range(0, 255));
		steps = $urandom_range(1, 10);
		send_event(KIND_DOWN, code);
		repeat (steps) begin
			case ($urandom_range(0, 7))
				0, 1, 2, 3: send_event(KIND_TICK, code);
				4, 5:       send_event(KIND_POLL, code);
				6:          send_event(KIND_POP, other);
				default:    send_event(KIND_DOWN, other);
			endcase
		end
		send_event(KIND_UP, ($urandom_range(0, 3) == 0) ? other : code);
		repeat ($urandom_range(0, 3))
			send_event(KIND_POP, code);
	endtask

	// Hand-picked events covering each event kind and the corner cases.
	task automatic test_directed_cases();
		write_reg(REG_SPARE_2, 16'hA5C3);
		set_timing(16'd3, 16'd2);
		send_event(KIND_POP, 8'h00);
		send_event(KIND_DOWN, 8'h05);
		send_event(KIND_DOWN, 8'hFF);
		send_event(KIND_POLL, 8'h05);
		repeat (3) send_event(KIND_TICK, 8'h05);
		// A tick with the countdown already at zero.
		send_event(KIND_TICK, 8'hFF);
		send_event(KIND_POLL, 8'h05);
		send_event(KIND_POP, 8'h05);
		// Releasing a different key still stops the repeat.
		send_event(KIND_UP, 8'h3F);
		send_event(KIND_TICK, 8'h05);
		send_event(KIND_TICK, 8'h05);
		send_event(KIND_POLL, 8'h05);
		repeat (3) send_event(KIND_POP, 8'h05);
		send_event(KIND_SPARE_6, 8'h05);
		send_event(KIND_SPARE_7, 8'h3F);
		send_event(KIND_DOWN, 8'h3F);
		send_event(KIND_DOWN, 8'h40);
		send_event(KIND_UP, 8'hC8);
		send_event(KIND_CLEAR, 8'h05);
		send_event(KIND_POP, 8'h3F);
		send_event(KIND_DOWN, 8'h00);
	endtask

	// Overflow the ring with zero repeat timing and no idling, then drain it.
	task automatic test_fill_and_drop();
		logic [KEY_W-1:0] code;
		set_timing(16'd0, 16'd0);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int i = 0; i < FIFO_DEPTH + 4; i++) begin
			code = KEY_W'($urandom_range(0, 255));
			if (i % 8 == 7)
				send_event(KIND_POLL, code);
			else
				send_event(KIND_DOWN, code);
		end
		repeat (3) send_event(KIND_POLL, 8'h01);
		send_event(KIND_UP, 8'h01);
		repeat (FIFO_DEPTH + 2) begin
			code = KEY_W'($urandom_range(0, 255));
			send_event(KIND_POP, code);
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// The sink holds off for a long stretch while events keep coming, so the
	// block backs up and stalls its input.
	task automatic test_output_backpressure();
		set_timing(16'd2, 16'd1);
		tx_idle_on = 1'b0;
		rx_hold_len = LONG_HOLD;
		repeat (6) type_key_sequence();
		tx_idle_on = 1'b1;
	endtask

	task automatic run_random_phase(logic [CNT_W-1:0] first_delay,
			logic [CNT_W-1:0] period, int n);
		int               stop_at;
		logic [KEY_W-1:0] code;
		set_timing(first_delay, period);
		tx_idle_on = $urandom_range(0, 3) != 0;
		rx_idle_on = $urandom_range(0, 3) != 0;
		stop_at = events_sent + n;
		while (events_sent < stop_at) begin
			code = KEY_W'($urandom_range(0, 255));
			case ($urandom_range(0, 19))
				0:             send_event(KIND_CLEAR, code);
				1, 2, 3, 4:    send_noise();
				5:             repeat ($urandom_range(1, 6)) send_event(KIND_POP, code);
				default:       type_key_sequence();
			endcase
		end
	endtask

	// Random traffic under several timing settings, extremes included.
	task automatic test_random_phases();
		run_random_phase(16'hFFFF, 16'hFFFF, 130);
		run_random_phase(CNT_W'($urandom_range(1, 6)), CNT_W'($urandom_range(0, 4)), 130);
		run_random_phase(CNT_W'($urandom_range(0, 3)), CNT_W'($urandom_range(0, 3)), 130);
		run_random_phase(CNT_W'($urandom_range(0, 65535)),
			CNT_W'($urandom_range(0, 65535)), 130);
		run_random_phase(16'd1, 16'd0, 130);
		write_reg(REG_SPARE_3, CNT_W'($urandom_range(0, 65535)));
		run_random_phase(CNT_W'($urandom_range(0, 8)), CNT_W'($urandom_range(0, 8)), 130);
	endtask

	// Result sink: waits a drawn number of cycles before each transfer, or a
	// long hold when one has been requested.
	initial begin : result_sink
		int wait_cycles;
		forever begin
			if (rx_hold_len > 0) begin
				wait_cycles = rx_hold_len;
				rx_hold_len = 0;
				long_holds++;
			end else begin
				wait_cycles = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Compare every output transfer with the oldest prediction.
	always @(posedge clk) begin : result_check
		kef_out_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (report_q.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: unexpected result %s", $realtime, fmt_report(out_data));
				mismatches++;
			end else begin
				want = report_q.pop_front();
				if (out_data.popped_key !== want.popped_key ||
						out_data.popped_valid !== want.popped_valid ||
						out_data.push_accepted !== want.push_accepted ||
						out_data.fifo_not_empty !== want.fifo_not_empty ||
						out_data.key_is_held !== want.key_is_held) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
							fmt_report(want), fmt_report(out_data));
					mismatches++;
				end
			end
		end
	end

	// Watchdog: ends the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (in_valid === 1'b1 && in_stall === 1'b1)
			stalled_offers++;
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0) ||
				(cfg_valid === 1'b1 && cfg_ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, report_q.size());
			$display("tb: FAIL");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_fill_and_drop();
		test_output_backpressure();
		test_random_phases();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("summary: %0d events, %0d results, %0d repeats, %0d pops, %0d drops",
			events_sent, results_seen, repeats_pushed, pops_seen, drops_seen);
		$display("summary: %0d stalled input cycles, %0d long holds, %0d register writes",
			stalled_offers, long_holds, cfg_writes);
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
